// ===== design/idm_pkg.sv =====
// Shared types and constants for the 64-bit integer divide and modulo block.
`timescale 1ns / 1ps

package idm_pkg;

   localparam int DATA_W    = 64;
   localparam int DIV_STEPS = DATA_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // command codes
   localparam logic [1:0] CMD_SQUO = 2'd0;
   localparam logic [1:0] CMD_SREM = 2'd1;
   localparam logic [1:0] CMD_UQUO = 2'd2;
   localparam logic [1:0] CMD_UREM = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } idm_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              divide_by_zero;
   } idm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG_A,
      ST_NEG_B,
      ST_DIV,
      ST_FIX,
      ST_RESP
   } idm_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_NEG_A,
      OP_NEG_B,
      OP_STEP,
      OP_FIX
   } idm_op_type;

   typedef struct packed {
      logic       load;
      idm_op_type op;
   } idm_ctl_type;

endpackage

// ===== design/idm_datapath.sv =====
// Operand registers and the shared subtractor of the restoring divider.
`timescale 1ns / 1ps

module idm_datapath (
   input  logic                 clock,
   input  idm_pkg::idm_ctl_type ctl,
   input  idm_pkg::idm_req_type req_data,
   output idm_pkg::idm_rsp_type rsp_data
);

   localparam int W = idm_pkg::DATA_W;

   logic [1:0]   cmd_ff, cmd_in;
   logic [W-1:0] nq_ff, nq_in;   // dividend bits out at the top, quotient bits in at the bottom
   logic [W-1:0] d_ff, d_in;
   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] res_ff, res_in;
   logic         na_ff, na_in;
   logic         nb_ff, nb_in;
   logic         dz_ff, dz_in;

   logic         req_signed;
   logic [W-1:0] rsh;
   logic [W-1:0] sub_x, sub_y;
   logic [W:0]   diff;
   logic         take;
   logic         is_quo;
   logic         fix_neg;
   logic [W-1:0] sel;

   assign req_signed = req_data.command inside {idm_pkg::CMD_SQUO, idm_pkg::CMD_SREM};
   assign is_quo     = cmd_ff inside {idm_pkg::CMD_SQUO, idm_pkg::CMD_UQUO};
   assign sel        = is_quo ? nq_ff : r_ff;
   assign fix_neg    = is_quo ? (na_ff ^ nb_ff) : na_ff;
   assign rsh        = {r_ff[W-2:0], nq_ff[W-1]};

   // one subtractor serves negation, the division steps and the sign fixup
   always_comb begin
      sub_x = '0;
      sub_y = '0;
      case (ctl.op)
         idm_pkg::OP_NEG_A: begin
            sub_y = nq_ff;
         end
         idm_pkg::OP_NEG_B: begin
            sub_y = d_ff;
         end
         idm_pkg::OP_STEP: begin
            sub_x = rsh;
            sub_y = d_ff;
         end
         idm_pkg::OP_FIX: begin
            sub_y = sel;
         end
         default: begin
            sub_x = '0;
            sub_y = '0;
         end
      endcase
   end

   assign diff = {1'b0, sub_x} - {1'b0, sub_y};
   // bit shifted out of r counts as 2^64, so it always fits
   assign take = r_ff[W-1] | ~diff[W];

   always_comb begin
      cmd_in = cmd_ff;
      nq_in  = nq_ff;
      d_in   = d_ff;
      r_in   = r_ff;
      res_in = res_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      dz_in  = dz_ff;
      if (ctl.load) begin
         cmd_in = req_data.command;
         nq_in  = req_data.dividend;
         d_in   = req_data.divisor;
         r_in   = '0;
         na_in  = req_signed & req_data.dividend[W-1];
         nb_in  = req_signed & req_data.divisor[W-1];
         dz_in  = (req_data.divisor == '0);
      end else begin
         case (ctl.op)
            idm_pkg::OP_NEG_A: begin
               if (na_ff) nq_in = diff[W-1:0];
            end
            idm_pkg::OP_NEG_B: begin
               if (nb_ff) d_in = diff[W-1:0];
            end
            idm_pkg::OP_STEP: begin
               r_in  = take ? diff[W-1:0] : rsh;
               nq_in = {nq_ff[W-2:0], take};
            end
            idm_pkg::OP_FIX: begin
               if (dz_ff) res_in = '0;
               else       res_in = fix_neg ? diff[W-1:0] : sel;
            end
            default: begin
               res_in = res_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      nq_ff  <= nq_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      res_ff <= res_in;
      na_ff  <= na_in;
      nb_ff  <= nb_in;
      dz_ff  <= dz_in;
   end

   assign rsp_data.result         = res_ff;
   assign rsp_data.divide_by_zero = dz_ff;

endmodule

// ===== design/idm_control.sv =====
// Sequencer: operand negation, 64 division steps, sign fixup and handshakes.
`timescale 1ns / 1ps

module idm_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output idm_pkg::idm_ctl_type ctl
);

   localparam int CW = idm_pkg::CNT_W;
   localparam logic [CW-1:0] LAST_STEP = CW'(idm_pkg::DIV_STEPS - 1);

   idm_pkg::idm_state_type state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         idm_pkg::ST_IDLE:  if (req_valid) state_in = idm_pkg::ST_NEG_A;
         idm_pkg::ST_NEG_A: state_in = idm_pkg::ST_NEG_B;
         idm_pkg::ST_NEG_B: state_in = idm_pkg::ST_DIV;
         idm_pkg::ST_DIV:   if (cnt_ff == LAST_STEP) state_in = idm_pkg::ST_FIX;
         idm_pkg::ST_FIX:   state_in = idm_pkg::ST_RESP;
         idm_pkg::ST_RESP:  if (rsp_ready) state_in = idm_pkg::ST_IDLE;
         default:           state_in = idm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctl.load  = 1'b0;
      ctl.op    = idm_pkg::OP_NONE;
      case (state_ff)
         idm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         idm_pkg::ST_NEG_A: ctl.op = idm_pkg::OP_NEG_A;
         idm_pkg::ST_NEG_B: ctl.op = idm_pkg::OP_NEG_B;
         idm_pkg::ST_DIV:   ctl.op = idm_pkg::OP_STEP;
         idm_pkg::ST_FIX:   ctl.op = idm_pkg::OP_FIX;
         idm_pkg::ST_RESP:  rsp_valid = 1'b1;
         default:           ctl.op = idm_pkg::OP_NONE;
      endcase
   end

   assign cnt_in = (state_ff == idm_pkg::ST_DIV) ? cnt_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/int64_divide_modulo.sv =====
// Top level of the 64-bit signed/unsigned integer divide and modulo block.
// After item acceptance the sequencer runs the NEG_A and NEG_B negation states,
// 64 restoring steps on the shared subtractor and the fixup state, then presents the registered result.
// Items are not overlapped; req_ready is low until the result is taken.
// Reset (synchronous, active high) returns the sequencer to idle; data registers keep their value.
`timescale 1ns / 1ps

module int64_divide_modulo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  idm_pkg::idm_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output idm_pkg::idm_rsp_type rsp_data
);

   idm_pkg::idm_ctl_type ctl;

   idm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   idm_datapath u_datapath (
      .clock    (clock),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== design/idm_checker.sv =====
// Port-level assertions for the divider, bound to the top level.
`timescale 1ns / 1ps

module idm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input idm_pkg::idm_rsp_type rsp_data
);

   // one item in flight at a time
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   // fixed latency through the sequencer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##68 rsp_valid)
      else $error("result not presented 68 cycles after acceptance");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("block not busy after accepting an item");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_by_zero) |-> (rsp_data.result == '0))
      else $error("divide by zero with nonzero result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind int64_divide_modulo idm_checker u_idm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
